// ===== src/tgtp_pkg.sv =====
// ----------------------------------------------------------------------------
// tgtp_pkg
// Shared types, codes and helper functions of the text/graphics terminal
// parser.
// ----------------------------------------------------------------------------
package tgtp_pkg;

    // Default geometry handed to the top-level parameters.
    localparam int TEXT_COLS_DEF = 10;
    localparam int TEXT_ROWS_DEF = 8;
    localparam int GFX_SIDE_DEF  = 64;

    // Item actions.
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_CELL  = 2'd1;
    localparam logic [1:0] ACT_PIXEL = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Display stream byte codes.
    localparam logic [7:0] BYTE_NUL        = 8'd0;
    localparam logic [7:0] BYTE_CR         = 8'd13;
    localparam logic [7:0] BYTE_ESC        = 8'd27;
    localparam logic [7:0] BYTE_SPACE      = 8'd32;
    localparam logic [7:0] BYTE_DEL        = 8'd127;
    localparam logic [7:0] BYTE_HARD_RESET = 8'd255;

    // Escape command codes.
    localparam logic [7:0] ESC_RESET_GREEN = 8'd1;
    localparam logic [7:0] ESC_RESET_GREY  = 8'd2;

    // Pen colour codes.
    localparam logic [5:0] PEN_GREY  = 6'd42;
    localparam logic [5:0] PEN_GREEN = 6'd12;

    // Graphics command field (top two bits of a graphics byte).
    localparam logic [1:0] GCMD_PLOT  = 2'b00;
    localparam logic [1:0] GCMD_SET_X = 2'b01;
    localparam logic [1:0] GCMD_SET_Y = 2'b10;
    localparam logic [1:0] GCMD_CTRL  = 2'b11;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic [3:0] read_col;
        logic [2:0] read_row;
        logic [5:0] read_px;
        logic [5:0] read_py;
    } item_t;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [23:0] read_rgb;
        logic        graphics_on;
        logic        escape_on;
        logic [3:0]  cursor_col;
        logic [2:0]  cursor_row;
        logic [5:0]  point_x;
        logic [5:0]  point_y;
        logic [23:0] pen_rgb;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PREP,
        ST_PUT,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TEXT_RD,
        OP_PIX_RD,
        OP_GFX,
        OP_ESCAPE,
        OP_ESC_ARM,
        OP_HARD_RESET,
        OP_NEWLINE,
        OP_STEP_LEFT,
        OP_FILL_ZERO,
        OP_PUT
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
        logic put_space;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic       gfx;
        logic       esc;
        logic       row_ok;
        logic       busy;
        logic       out_free;
    } status_t;

    // A 2-bit colour level expands to 0, 63, 127 or 255.
    function automatic logic [7:0] level(input logic [1:0] lv);
        logic [7:0] res;
        unique case (lv)
            2'd0:    res = 8'd0;
            2'd1:    res = 8'd63;
            2'd2:    res = 8'd127;
            default: res = 8'd255;
        endcase
        return res;
    endfunction

    // Red sits in code bits 1:0, green in 3:2, blue in 5:4.
    function automatic logic [23:0] expand(input logic [5:0] code);
        return {level(code[1:0]), level(code[3:2]), level(code[5:4])};
    endfunction

endpackage

// ===== src/text_graphics_terminal_parser.sv =====
// A read, status or mode transaction is decoded and its result then loaded; a carriage
// return also waits out any scroll, and a printable byte or backspace passes through the
// prepare, put and wait states. A scroll waits for a row fill with spaces, and a row not
// written since the last text reset is first zeroed by a row fill of its own.
// One transaction at a time: the next one is accepted at the earliest in the cycle after
// the result is loaded, and a stalled result holds it off. Reset and byte 255 start a
// clearing pass over the whole pixel store during which s_ready stays low.
// ----------------------------------------------------------------------------
// text_graphics_terminal_parser
// Terminal parser that interprets a display byte stream into a text grid and
// a pixel store, and serves reads of both stores.
// ----------------------------------------------------------------------------
module text_graphics_terminal_parser #(
    parameter int TEXT_COLS = tgtp_pkg::TEXT_COLS_DEF,
    parameter int TEXT_ROWS = tgtp_pkg::TEXT_ROWS_DEF,
    parameter int GFX_SIDE  = tgtp_pkg::GFX_SIDE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tgtp_pkg::item_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tgtp_pkg::result_t m_data
);

    // The controller sequences each transaction with its own state registers; the
    // datapath owns every store and the remaining registers. They talk only through the command and status
    // structs below.
    tgtp_pkg::cmd_t    cmd;
    tgtp_pkg::status_t sts;

    tgtp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The text grid rotates its rows on scroll, so a scroll costs one row
    // fill rather than a copy of the whole grid. Rows carry valid bits so a
    // text reset takes effect at once.
    tgtp_dp #(
        .TEXT_COLS (TEXT_COLS),
        .TEXT_ROWS (TEXT_ROWS),
        .GFX_SIDE  (GFX_SIDE)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Only one transaction is in flight, so ready drops right after acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction is still in flight");

    // The reported cursor always lies inside the grid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.cursor_col) < TEXT_COLS))
        else $error("cursor column outside the text grid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.cursor_row) < TEXT_ROWS))
        else $error("cursor row outside the text grid");

endmodule

// ===== src/tgtp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgtp_ctrl
// Sequencer of the terminal parser: decodes each transaction into datapath
// operations and waits out the multi-cycle fills and clears.
// ----------------------------------------------------------------------------
module tgtp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tgtp_pkg::status_t sts,
    output tgtp_pkg::cmd_t    cmd
);

    tgtp_pkg::state_t state_reg, state_next;
    logic bs_reg, bs_next;
    logic put_pend_reg, put_pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tgtp_pkg::ST_IDLE;
            bs_reg       <= 1'b0;
            put_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bs_reg       <= bs_next;
            put_pend_reg <= put_pend_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        bs_next       = bs_reg;
        put_pend_next = put_pend_reg;
        cmd           = '{load: 1'b0, op: tgtp_pkg::OP_NONE, put_space: 1'b0, out_load: 1'b0};
        s_ready       = 1'b0;

        unique case (state_reg)
            tgtp_pkg::ST_IDLE: begin
                s_ready  = !sts.busy;
                cmd.load = s_valid && !sts.busy;
                if (s_valid && !sts.busy) begin
                    state_next = tgtp_pkg::ST_DECODE;
                end
            end
            tgtp_pkg::ST_DECODE: begin
                state_next = tgtp_pkg::ST_FINISH;
                unique case (sts.action)
                    tgtp_pkg::ACT_BYTE: begin
                        if (sts.gfx) begin
                            if (sts.data_byte == tgtp_pkg::BYTE_HARD_RESET) begin
                                cmd.op     = tgtp_pkg::OP_HARD_RESET;
                                state_next = tgtp_pkg::ST_WAIT;
                            end else if (sts.data_byte != tgtp_pkg::BYTE_NUL) begin
                                cmd.op = tgtp_pkg::OP_GFX;
                            end
                        end else if (sts.esc) begin
                            cmd.op = tgtp_pkg::OP_ESCAPE;
                        end else if (sts.data_byte == tgtp_pkg::BYTE_ESC) begin
                            cmd.op = tgtp_pkg::OP_ESC_ARM;
                        end else if (sts.data_byte == tgtp_pkg::BYTE_HARD_RESET) begin
                            cmd.op     = tgtp_pkg::OP_HARD_RESET;
                            state_next = tgtp_pkg::ST_WAIT;
                        end else if (sts.data_byte == tgtp_pkg::BYTE_CR) begin
                            cmd.op     = tgtp_pkg::OP_NEWLINE;
                            state_next = tgtp_pkg::ST_WAIT;
                        end else if (sts.data_byte == tgtp_pkg::BYTE_DEL) begin
                            cmd.op     = tgtp_pkg::OP_STEP_LEFT;
                            bs_next    = 1'b1;
                            state_next = tgtp_pkg::ST_PREP;
                        end else if (sts.data_byte >= tgtp_pkg::BYTE_SPACE) begin
                            state_next = tgtp_pkg::ST_PREP;
                        end
                    end
                    tgtp_pkg::ACT_CELL:  cmd.op = tgtp_pkg::OP_TEXT_RD;
                    tgtp_pkg::ACT_PIXEL: cmd.op = tgtp_pkg::OP_PIX_RD;
                    default:             cmd.op = tgtp_pkg::OP_NONE;
                endcase
            end
            tgtp_pkg::ST_PREP: begin
                // A row never written since the last text reset is zeroed first.
                if (sts.row_ok) begin
                    state_next = tgtp_pkg::ST_PUT;
                end else begin
                    cmd.op        = tgtp_pkg::OP_FILL_ZERO;
                    put_pend_next = 1'b1;
                    state_next    = tgtp_pkg::ST_WAIT;
                end
            end
            tgtp_pkg::ST_PUT: begin
                cmd.op        = tgtp_pkg::OP_PUT;
                cmd.put_space = bs_reg;
                state_next    = tgtp_pkg::ST_WAIT;
            end
            tgtp_pkg::ST_WAIT: begin
                if (!sts.busy) begin
                    if (put_pend_reg) begin
                        put_pend_next = 1'b0;
                        state_next    = tgtp_pkg::ST_PUT;
                    end else if (bs_reg) begin
                        cmd.op     = tgtp_pkg::OP_STEP_LEFT;
                        bs_next    = 1'b0;
                        state_next = tgtp_pkg::ST_FINISH;
                    end else begin
                        state_next = tgtp_pkg::ST_FINISH;
                    end
                end
            end
            tgtp_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = tgtp_pkg::ST_IDLE;
                end
            end
            default: state_next = tgtp_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== src/tgtp_dp.sv =====
// ----------------------------------------------------------------------------
// tgtp_dp
// Datapath of the terminal parser: cursor, pointer and mode registers, the
// text and pixel stores with their fill and clear sweeps, and the result
// register.
// ----------------------------------------------------------------------------
module tgtp_dp #(
    parameter int TEXT_COLS = tgtp_pkg::TEXT_COLS_DEF,
    parameter int TEXT_ROWS = tgtp_pkg::TEXT_ROWS_DEF,
    parameter int GFX_SIDE  = tgtp_pkg::GFX_SIDE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tgtp_pkg::item_t   s_data,
    input  tgtp_pkg::cmd_t    cmd,
    output tgtp_pkg::status_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output tgtp_pkg::result_t m_data
);

    localparam int COL_W  = $clog2(TEXT_COLS);
    localparam int ROW_W  = $clog2(TEXT_ROWS);
    localparam int CELLS  = TEXT_COLS * TEXT_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PIX_W  = $clog2(GFX_SIDE);
    localparam int PIX_A  = 2 * PIX_W;

    // Logical row to physical row under the scroll rotation.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lr,
                                                  input logic [ROW_W-1:0] ofs);
        logic [ROW_W:0] s;
        s = {1'b0, lr} + {1'b0, ofs};
        if (s >= (ROW_W+1)'(TEXT_ROWS)) begin
            s = s - (ROW_W+1)'(TEXT_ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] pr,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(pr) * ADDR_W'(TEXT_COLS) + ADDR_W'(c));
    endfunction

    tgtp_pkg::item_t item_reg;

    logic [COL_W-1:0]     cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]     cur_row_reg, cur_row_next;
    logic [PIX_W-1:0]     ptr_x_reg, ptr_x_next;
    logic [PIX_W-1:0]     ptr_y_reg, ptr_y_next;
    logic [5:0]           pen_reg, pen_next;
    logic                 esc_reg, esc_next;
    logic                 gfx_reg, gfx_next;
    logic [ROW_W-1:0]     row_ofs_reg, row_ofs_next;
    logic [TEXT_ROWS-1:0] row_vld_reg, row_vld_next;
    logic                 fill_active_reg, fill_active_next;
    logic [ROW_W-1:0]     fill_row_reg, fill_row_next;
    logic [COL_W-1:0]     fill_col_reg, fill_col_next;
    logic                 fill_space_reg, fill_space_next;
    logic                 clr_active_reg, clr_active_next;
    logic [PIX_A-1:0]     clr_addr_reg, clr_addr_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic                 m_valid_reg, m_valid_next;

    logic [13:0]       text_mem [CELLS];
    logic [13:0]       txt_rdata_reg;
    logic              txt_we, txt_re;
    logic [ADDR_W-1:0] txt_waddr, txt_raddr;
    logic [13:0]       txt_wdata;

    logic [5:0]       pix_mem [GFX_SIDE * GFX_SIDE];
    logic [5:0]       pix_rdata_reg;
    logic             pix_we, pix_re;
    logic [PIX_A-1:0] pix_waddr, pix_raddr;
    logic [5:0]       pix_wdata;

    logic             do_scroll, do_plot, do_text_reset;
    logic [5:0]       plot_code, reset_pen;
    logic [ROW_W-1:0] cur_prow, rd_prow;
    logic [7:0]       put_char;
    logic [7:0]       b;

    tgtp_pkg::result_t res;

    assign b        = item_reg.data_byte;
    assign cur_prow = phys_row(cur_row_reg, row_ofs_reg);
    assign rd_prow  = phys_row(ROW_W'(item_reg.read_row), row_ofs_reg);
    assign put_char = cmd.put_space ? tgtp_pkg::BYTE_SPACE : b;

    always_comb begin
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        ptr_x_next       = ptr_x_reg;
        ptr_y_next       = ptr_y_reg;
        pen_next         = pen_reg;
        esc_next         = esc_reg;
        gfx_next         = gfx_reg;
        row_ofs_next     = row_ofs_reg;
        row_vld_next     = row_vld_reg;
        fill_active_next = fill_active_reg;
        fill_row_next    = fill_row_reg;
        fill_col_next    = fill_col_reg;
        fill_space_next  = fill_space_reg;
        clr_active_next  = clr_active_reg;
        clr_addr_next    = clr_addr_reg;
        rd_ok_next       = rd_ok_reg;
        do_scroll        = 1'b0;
        do_plot          = 1'b0;
        do_text_reset    = 1'b0;
        plot_code        = '0;
        reset_pen        = tgtp_pkg::PEN_GREY;

        txt_we    = 1'b0;
        txt_waddr = cell_addr(fill_row_reg, fill_col_reg);
        txt_wdata = {6'd0, fill_space_reg ? tgtp_pkg::BYTE_SPACE : tgtp_pkg::BYTE_NUL};
        txt_re    = 1'b0;
        txt_raddr = cell_addr(rd_prow, COL_W'(item_reg.read_col));
        pix_we    = 1'b0;
        pix_waddr = clr_addr_reg;
        pix_wdata = '0;
        pix_re    = 1'b0;
        pix_raddr = {PIX_W'(item_reg.read_py), PIX_W'(item_reg.read_px)};

        // Row fill sweep: one cell per cycle.
        if (fill_active_reg) begin
            txt_we = 1'b1;
            if (fill_col_reg == COL_W'(TEXT_COLS - 1)) begin
                fill_active_next = 1'b0;
            end else begin
                fill_col_next = fill_col_reg + 1'b1;
            end
        end

        // Pixel clearing pass: one pixel per cycle.
        if (clr_active_reg) begin
            pix_we        = 1'b1;
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clr_active_next = 1'b0;
            end
        end

        unique case (cmd.op)
            tgtp_pkg::OP_TEXT_RD: begin
                txt_re     = 1'b1;
                rd_ok_next = (int'(item_reg.read_col) < TEXT_COLS)
                          && (int'(item_reg.read_row) < TEXT_ROWS)
                          && row_vld_reg[rd_prow];
            end
            tgtp_pkg::OP_PIX_RD: begin
                pix_re = 1'b1;
            end
            tgtp_pkg::OP_GFX: begin
                case (b[7:6])
                    tgtp_pkg::GCMD_CTRL: begin
                        if (b[5:0] == 6'd0) begin
                            gfx_next = 1'b0;
                        end else begin
                            do_plot = 1'b1;
                        end
                    end
                    tgtp_pkg::GCMD_SET_Y: ptr_y_next = PIX_W'(b[5:0]);
                    tgtp_pkg::GCMD_SET_X: ptr_x_next = PIX_W'(b[5:0]);
                    default: begin
                        do_plot   = 1'b1;
                        plot_code = b[5:0];
                    end
                endcase
            end
            tgtp_pkg::OP_ESCAPE: begin
                if (b != tgtp_pkg::BYTE_NUL) begin
                    esc_next = 1'b0;
                    if (b == tgtp_pkg::ESC_RESET_GREY) begin
                        gfx_next      = 1'b0;
                        do_text_reset = 1'b1;
                    end else if (b == tgtp_pkg::ESC_RESET_GREEN) begin
                        gfx_next      = 1'b0;
                        do_text_reset = 1'b1;
                        reset_pen     = tgtp_pkg::PEN_GREEN;
                    end else if (b[7]) begin
                        pen_next = b[5:0];
                    end else if (b[6]) begin
                        gfx_next = 1'b1;
                    end
                end
            end
            tgtp_pkg::OP_ESC_ARM: begin
                esc_next = 1'b1;
            end
            tgtp_pkg::OP_HARD_RESET: begin
                gfx_next        = 1'b0;
                esc_next        = 1'b0;
                do_text_reset   = 1'b1;
                ptr_x_next      = '0;
                ptr_y_next      = '0;
                clr_active_next = 1'b1;
                clr_addr_next   = '0;
            end
            tgtp_pkg::OP_NEWLINE: begin
                cur_col_next = '0;
                if (cur_row_reg == ROW_W'(TEXT_ROWS - 1)) begin
                    do_scroll = 1'b1;
                end else begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            tgtp_pkg::OP_STEP_LEFT: begin
                if (cur_col_reg == '0) begin
                    cur_col_next = COL_W'(TEXT_COLS - 1);
                    cur_row_next = (cur_row_reg == '0) ? ROW_W'(TEXT_ROWS - 1)
                                                       : cur_row_reg - 1'b1;
                end else begin
                    cur_col_next = cur_col_reg - 1'b1;
                end
            end
            tgtp_pkg::OP_FILL_ZERO: begin
                fill_active_next      = 1'b1;
                fill_row_next         = cur_prow;
                fill_col_next         = '0;
                fill_space_next       = 1'b0;
                row_vld_next[cur_prow] = 1'b1;
            end
            tgtp_pkg::OP_PUT: begin
                txt_we    = 1'b1;
                txt_waddr = cell_addr(cur_prow, cur_col_reg);
                txt_wdata = {pen_reg, put_char};
                if (cur_col_reg == COL_W'(TEXT_COLS - 1)) begin
                    cur_col_next = '0;
                    if (cur_row_reg == ROW_W'(TEXT_ROWS - 1)) begin
                        do_scroll = 1'b1;
                    end else begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end else begin
                    cur_col_next = cur_col_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Scroll rotates the row map; the old top row becomes the new bottom
        // row and is filled with spaces.
        if (do_scroll) begin
            fill_active_next          = 1'b1;
            fill_row_next             = row_ofs_reg;
            fill_col_next             = '0;
            fill_space_next           = 1'b1;
            row_vld_next[row_ofs_reg] = 1'b1;
            row_ofs_next = (row_ofs_reg == ROW_W'(TEXT_ROWS - 1)) ? '0 : row_ofs_reg + 1'b1;
        end

        if (do_plot) begin
            pix_we    = 1'b1;
            pix_waddr = {ptr_y_reg, ptr_x_reg};
            pix_wdata = plot_code;
            ptr_x_next = ptr_x_reg + 1'b1;
            if (ptr_x_reg == PIX_W'(GFX_SIDE - 1)) begin
                ptr_y_next = ptr_y_reg + 1'b1;
            end
        end

        if (do_text_reset) begin
            cur_col_next = '0;
            cur_row_next = '0;
            pen_next     = reset_pen;
            row_vld_next = '0;
        end
    end

    always_comb begin
        res             = '0;
        res.graphics_on = gfx_reg;
        res.escape_on   = esc_reg;
        res.cursor_col  = 4'(cur_col_reg);
        res.cursor_row  = 3'(cur_row_reg);
        res.point_x     = 6'(ptr_x_reg);
        res.point_y     = 6'(ptr_y_reg);
        res.pen_rgb     = tgtp_pkg::expand(pen_reg);
        if (item_reg.action == tgtp_pkg::ACT_CELL && rd_ok_reg) begin
            res.cell_char = txt_rdata_reg[7:0];
            res.read_rgb  = tgtp_pkg::expand(txt_rdata_reg[13:8]);
        end else if (item_reg.action == tgtp_pkg::ACT_PIXEL) begin
            res.read_rgb  = tgtp_pkg::expand(pix_rdata_reg);
        end
    end

    assign m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            ptr_x_reg       <= '0;
            ptr_y_reg       <= '0;
            pen_reg         <= tgtp_pkg::PEN_GREY;
            esc_reg         <= 1'b0;
            gfx_reg         <= 1'b0;
            row_ofs_reg     <= '0;
            row_vld_reg     <= '0;
            fill_active_reg <= 1'b0;
            fill_row_reg    <= '0;
            fill_col_reg    <= '0;
            fill_space_reg  <= 1'b0;
            clr_active_reg  <= 1'b1;
            clr_addr_reg    <= '0;
            rd_ok_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            ptr_x_reg       <= ptr_x_next;
            ptr_y_reg       <= ptr_y_next;
            pen_reg         <= pen_next;
            esc_reg         <= esc_next;
            gfx_reg         <= gfx_next;
            row_ofs_reg     <= row_ofs_next;
            row_vld_reg     <= row_vld_next;
            fill_active_reg <= fill_active_next;
            fill_row_reg    <= fill_row_next;
            fill_col_reg    <= fill_col_next;
            fill_space_reg  <= fill_space_next;
            clr_active_reg  <= clr_active_next;
            clr_addr_reg    <= clr_addr_next;
            rd_ok_reg       <= rd_ok_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.out_load) begin
            m_data <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (txt_we) begin
            text_mem[txt_waddr] <= txt_wdata;
        end
        if (txt_re) begin
            txt_rdata_reg <= text_mem[txt_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_we) begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        if (pix_re) begin
            pix_rdata_reg <= pix_mem[pix_raddr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign sts.action    = item_reg.action;
    assign sts.data_byte = item_reg.data_byte;
    assign sts.gfx       = gfx_reg;
    assign sts.esc       = esc_reg;
    assign sts.row_ok    = row_vld_reg[cur_prow];
    assign sts.busy      = fill_active_reg || clr_active_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

endmodule
